>>> rtl/shortest_path_dense_graph_macros.svh
// Assertion macros for the shortest path block.
// Depends on clk and rst being visible at the point of use.
`ifndef SHORTEST_PATH_DENSE_GRAPH_MACROS_SVH
`define SHORTEST_PATH_DENSE_GRAPH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SPDG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SPDG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPDG_ASSERT_SAME(label, ante, cons, msg)
`define SPDG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/spdg_pkg.sv
// Shared constants for the shortest path block: field widths, defaults, codes.
// No dependencies.
`default_nettype none

package spdg_pkg;

  localparam int unsigned VERTICES_DEFAULT    = 16;
  localparam int unsigned WEIGHT_BITS_DEFAULT = 16;
  localparam int unsigned MAX_RESULTS         = 16;
  localparam int unsigned PATH_LEN_BITS       = $clog2(MAX_RESULTS);

  localparam int unsigned VC_BITS        = 5;
  localparam logic [VC_BITS-1:0] VC_RESET = 5'd16;

  localparam int unsigned VERTEX_BITS    = 4;
  localparam int unsigned WEIGHT_IN_BITS = 16;
  localparam int unsigned DIST_OUT_BITS  = 20;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> rtl/shortest_path_dense_graph.sv
// Top level of the shortest path block: weight memory, sequencer, result register.
// Depends on spdg_pkg, spdg_alu and shortest_path_dense_graph_macros.svh.
//
// Channel     | Handshake             | Payload
// ------------+-----------------------+----------------------------------------------
// request     | req_valid / req_ready | mode, edge_from, edge_to, edge_weight,
//             |                       | source, destination
// result      | rsp_valid / rsp_ready | found, total_distance, path_vertex, last
// config      | cfg_write_en          | cfg_write_data (vertex_count)
//
// A load request with both vertices in range is written as it is accepted, and the
// sequencer stays idle. A query scans the vertices in use for each round's pick, then
// relaxes the picked row for each round whose pick is reached, then walks the path back
// from the destination and issues it source first; the one add-and-compare unit and the
// single read port of the weight memory set the pace of the scan and the relax.
// After reset the weight memory is swept to zero with req_ready low.
// Result stalls hold the sequencer in its issue state; req_ready is high only while
// the sequencer idles.
`default_nettype none
`include "shortest_path_dense_graph_macros.svh"

module shortest_path_dense_graph #(
  parameter int unsigned VERTICES    = spdg_pkg::VERTICES_DEFAULT,
  parameter int unsigned WEIGHT_BITS = spdg_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write_en,
  input  logic [spdg_pkg::VC_BITS-1:0]        cfg_write_data,
  // request channel
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                mode,
  input  logic [spdg_pkg::VERTEX_BITS-1:0]    edge_from,
  input  logic [spdg_pkg::VERTEX_BITS-1:0]    edge_to,
  input  logic [spdg_pkg::WEIGHT_IN_BITS-1:0] edge_weight,
  input  logic [spdg_pkg::VERTEX_BITS-1:0]    source,
  input  logic [spdg_pkg::VERTEX_BITS-1:0]    destination,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                found,
  output logic [spdg_pkg::DIST_OUT_BITS-1:0]  total_distance,
  output logic [spdg_pkg::VERTEX_BITS-1:0]    path_vertex,
  output logic                                last
);

  import spdg_pkg::*;

  // Vertices a query can touch, and the widths that follow.
  localparam int unsigned NV        = (VERTICES < MAX_RESULTS) ? VERTICES : MAX_RESULTS;
  localparam int unsigned IW        = $clog2(NV);
  localparam int unsigned CW        = $clog2(NV + 1);
  localparam int unsigned MEM_DEPTH = VERTICES * VERTICES;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned DW        = WEIGHT_BITS + PATH_LEN_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_RELAX, S_DONE, S_WALK, S_EMIT, S_MISS
  } state_t;

  state_t state;

  // Control registers
  logic [AW-1:0]      clr_addr;
  logic [VC_BITS-1:0] vertex_count;
  logic [CW-1:0]      n_cur;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      rounds_left;
  logic [CW-1:0]      depth;
  logic               any_pick;
  logic               rvalid;
  logic [IW-1:0]      src;
  logic [IW-1:0]      dst;
  logic [IW-1:0]      wv;
  logic [IW-1:0]      ptr;
  logic [NV-1:0]      reached;
  logic [NV-1:0]      visited;
  logic [NV-1:0]      has_pred;

  // Payload registers
  logic [DW-1:0]      dist_tab [NV];
  logic [IW-1:0]      pred [NV];
  logic [IW-1:0]      stack [NV];
  logic [IW-1:0]      u;
  logic [DW-1:0]      ud;
  logic               ur;
  logic [IW-1:0]      rv;
  logic [DW-1:0]      dst_dist;

  // Weight memory
  logic [WEIGHT_BITS-1:0] weight_mem [MEM_DEPTH];
  logic [WEIGHT_BITS-1:0] mem_rd;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          rd_addr;

  // Combinational helpers
  logic [CW-1:0]                    n_eff;
  logic                             q_in_range;
  logic                             ld_in_range;
  logic [IW-1:0]                    src_in;
  logic [IW-1:0]                    dst_in;
  logic [AW-1:0]                    ld_addr;
  logic [WEIGHT_BITS+WEIGHT_IN_BITS-1:0] w_ext;
  logic [IW-1:0]                    cnt_idx;
  logic                             cnt_live;
  logic [IW-1:0]                    dist_idx;
  logic [DW-1:0]                    dist_rd;
  logic [DW-1:0]                    alu_sum;
  logic                             alu_less;
  logic                             take;
  logic                             rel_upd;
  logic                             out_free;
  logic [DW+DIST_OUT_BITS-1:0]      dist_ext;
  logic [DIST_OUT_BITS-1:0]         dist_sat;

  // Clamp the vertex count: zero acts as one, cap at what the block holds.
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = CW'(1);
    end else if (vertex_count > VC_BITS'(NV)) begin
      n_eff = CW'(NV);
    end else begin
      n_eff = CW'(vertex_count);
    end
  end

  assign q_in_range  = (source < n_eff) && (destination < n_eff);
  assign ld_in_range = (edge_from < VERTICES) && (edge_to < VERTICES);
  assign src_in      = IW'(source);
  assign dst_in      = IW'(destination);
  assign ld_addr     = AW'(edge_from) * AW'(VERTICES) + AW'(edge_to);
  assign w_ext       = (WEIGHT_BITS + WEIGHT_IN_BITS)'(edge_weight);

  assign cnt_idx  = cnt[IW-1:0];
  assign cnt_live = (cnt < n_cur);

  // One read port on the distance table: scan vertex, relax vertex, or destination.
  always_comb begin
    unique case (state)
      S_SCAN:  dist_idx = cnt_idx;
      S_RELAX: dist_idx = rv;
      default: dist_idx = dst;
    endcase
  end
  assign dist_rd = dist_tab[dist_idx];

  spdg_alu #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .DIST_BITS   (DW)
  ) u_alu (
    .base    (ud),
    .addend  (mem_rd),
    .add_en  (state == S_RELAX),
    .cmp_ref (dist_rd),
    .sum     (alu_sum),
    .less    (alu_less)
  );

  // Scan pick: least distance wins, ties go to the higher index, unreached is farthest.
  assign take = (state == S_SCAN) && cnt_live && !visited[cnt_idx] &&
                (!any_pick || (reached[cnt_idx] ? (!ur || !alu_less) : !ur));

  // Relax: improve an unvisited neighbor over a real edge.
  assign rel_upd = (state == S_RELAX) && rvalid && !visited[rv] && (mem_rd != '0) &&
                   (!reached[rv] || alu_less);

  assign out_free = !rsp_valid || rsp_ready;

  // Saturate the reported distance to the output width.
  assign dist_ext = (DW + DIST_OUT_BITS)'(dst_dist);
  assign dist_sat = (|dist_ext[DW+DIST_OUT_BITS-1:DIST_OUT_BITS]) ? '1 :
                    dist_ext[DIST_OUT_BITS-1:0];

  // Memory ports: clearing sweep or load on write, the picked row on read.
  assign mem_we    = (state == S_CLEAR) ||
                     ((state == S_IDLE) && req_valid && (mode == MODE_LOAD) && ld_in_range);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : ld_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : w_ext[WEIGHT_BITS-1:0];
  assign mem_re    = (state == S_RELAX) && cnt_live;
  assign rd_addr   = AW'(u) * AW'(VERTICES) + AW'(cnt_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      weight_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd <= weight_mem[rd_addr];
    end
  end

  assign req_ready = (state == S_IDLE);

  // Payload updates: distances, predecessors, path stack, current pick.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_valid && (mode == MODE_QUERY)) begin
      dist_tab[src_in] <= '0;
    end
    if (take) begin
      u  <= cnt_idx;
      ud <= dist_rd;
      ur <= reached[cnt_idx];
    end
    if (mem_re) begin
      rv <= cnt_idx;
    end
    if (rel_upd) begin
      dist_tab[rv] <= alu_sum;
      pred[rv]     <= u;
    end
    if (state == S_WALK) begin
      stack[depth[IW-1:0]] <= wv;
      dst_dist             <= dist_rd;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      vertex_count   <= VC_RESET;
      n_cur          <= '0;
      cnt            <= '0;
      rounds_left    <= '0;
      depth          <= '0;
      any_pick       <= 1'b0;
      rvalid         <= 1'b0;
      src            <= '0;
      dst            <= '0;
      wv             <= '0;
      ptr            <= '0;
      reached        <= '0;
      visited        <= '0;
      has_pred       <= '0;
      rsp_valid      <= 1'b0;
      found          <= 1'b0;
      total_distance <= '0;
      path_vertex    <= '0;
      last           <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        vertex_count <= cfg_write_data;
      end
      // Drop the result once taken; a new load below overrides this.
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          // Sweep the weight memory to "no edge".
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req_valid && (mode == MODE_QUERY)) begin
            n_cur <= n_eff;
            src   <= src_in;
            dst   <= dst_in;
            if (!q_in_range) begin
              state <= S_MISS;
            end else begin
              reached         <= '0;
              reached[src_in] <= 1'b1;
              visited         <= '0;
              has_pred        <= '0;
              rounds_left     <= n_eff - CW'(1);
              cnt             <= '0;
              any_pick        <= 1'b0;
              state           <= (n_eff == CW'(1)) ? S_DONE : S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (cnt_live) begin
            // Advance through the vertex list, one compare a cycle.
            cnt <= cnt + CW'(1);
            if (take) begin
              any_pick <= 1'b1;
            end
          end else if (!any_pick) begin
            state <= S_DONE;
          end else begin
            visited[u] <= 1'b1;
            if (ur) begin
              cnt    <= '0;
              rvalid <= 1'b0;
              state  <= S_RELAX;
            end else if (rounds_left == CW'(1)) begin
              state <= S_DONE;
            end else begin
              // An unreached pick relaxes nothing: start the next round.
              rounds_left <= rounds_left - CW'(1);
              cnt         <= '0;
              any_pick    <= 1'b0;
              state       <= S_SCAN;
            end
          end
        end

        S_RELAX: begin
          // Row reads are registered: the compare on the returned weight follows in the next cycle.
          if (cnt_live) begin
            cnt    <= cnt + CW'(1);
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
            if (rounds_left == CW'(1)) begin
              state <= S_DONE;
            end else begin
              rounds_left <= rounds_left - CW'(1);
              cnt         <= '0;
              any_pick    <= 1'b0;
              state       <= S_SCAN;
            end
          end
          if (rel_upd) begin
            reached[rv]  <= 1'b1;
            has_pred[rv] <= 1'b1;
          end
        end

        S_DONE: begin
          if (reached[dst]) begin
            wv    <= dst;
            depth <= '0;
            state <= S_WALK;
          end else begin
            state <= S_MISS;
          end
        end

        S_WALK: begin
          // Push the chain from destination back to source.
          depth <= depth + CW'(1);
          if (has_pred[wv]) begin
            wv <= pred[wv];
          end else begin
            ptr   <= depth[IW-1:0];
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          // Pop the stack: source first, destination last.
          if (out_free) begin
            rsp_valid      <= 1'b1;
            found          <= 1'b1;
            total_distance <= dist_sat;
            path_vertex    <= VERTEX_BITS'(stack[ptr]);
            last           <= (ptr == '0);
            ptr            <= ptr - IW'(1);
            if (ptr == '0) begin
              state <= S_IDLE;
            end
          end
        end

        S_MISS: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            found          <= 1'b0;
            total_distance <= '0;
            path_vertex    <= '0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `SPDG_ASSERT_NEXT(a_query_busy, req_valid && req_ready && mode == MODE_QUERY, !req_ready, "query accepted but request side still ready")
  `SPDG_ASSERT_SAME(a_relax_from_pick, rvalid, reached[u] && visited[u], "relaxing from a vertex that is not a reached, visited pick")
  `SPDG_ASSERT_SAME(a_walk_bound, state == S_WALK, depth < n_cur, "path walk longer than the vertex count")
  `SPDG_ASSERT_SAME(a_src_root, state == S_SCAN || state == S_RELAX, reached[src] && !has_pred[src], "source lost its root status")
  `SPDG_ASSERT_SAME(a_miss_shape, rsp_valid && !found, last && total_distance == '0 && path_vertex == '0, "not-found result with stray fields")

endmodule

`default_nettype wire

>>> rtl/spdg_alu.sv
// Shared add-and-compare unit of the shortest path sequencer.
// Depends on spdg_pkg for parameter defaults.
`default_nettype none

module spdg_alu #(
  parameter int unsigned WEIGHT_BITS = spdg_pkg::WEIGHT_BITS_DEFAULT,
  parameter int unsigned DIST_BITS   = WEIGHT_BITS + spdg_pkg::PATH_LEN_BITS
) (
  input  logic [DIST_BITS-1:0]   base,
  input  logic [WEIGHT_BITS-1:0] addend,
  input  logic                   add_en,
  input  logic [DIST_BITS-1:0]   cmp_ref,
  output logic [DIST_BITS-1:0]   sum,
  output logic                   less
);

  // Operand is base, or base plus edge weight; compare it against the reference.
  assign sum  = add_en ? (base + DIST_BITS'(addend)) : base;
  assign less = (sum < cmp_ref);

endmodule

`default_nettype wire

>>> dv/shortest_path_dense_graph_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for shortest_path_dense_graph: edge loads and route queries.
// Depends on spdg_pkg and the shortest_path_dense_graph RTL; needs no other files.

module shortest_path_dense_graph_test;
  import spdg_pkg::*;

  localparam int unsigned VERTEX_SLOTS = VERTICES_DEFAULT;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [DIST_OUT_BITS-1:0] DIST_CAP = '1;
  localparam int unsigned IDLE_PERCENT = 18;

  // One request as the sender holds it. drain_first makes the sender hold the
  // request back until every route already predicted has been received.
  typedef struct packed {
    logic                      mode;
    logic [VERTEX_BITS-1:0]    edge_from;
    logic [VERTEX_BITS-1:0]    edge_to;
    logic [WEIGHT_IN_BITS-1:0] edge_weight;
    logic [VERTEX_BITS-1:0]    source;
    logic [VERTEX_BITS-1:0]    destination;
    logic                      drain_first;
  } request_t;

  // One step of a reported route.
  typedef struct packed {
    logic                     found;
    logic [DIST_OUT_BITS-1:0] total_distance;
    logic [VERTEX_BITS-1:0]   path_vertex;
    logic                     last;
  } path_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_write_en   = 1'b0;
  logic [VC_BITS-1:0]        cfg_write_data = '0;
  logic                      req_valid      = 1'b0;
  logic                      req_ready;
  logic                      mode           = MODE_LOAD;
  logic [VERTEX_BITS-1:0]    edge_from      = '0;
  logic [VERTEX_BITS-1:0]    edge_to        = '0;
  logic [WEIGHT_IN_BITS-1:0] edge_weight    = '0;
  logic [VERTEX_BITS-1:0]    source         = '0;
  logic [VERTEX_BITS-1:0]    destination    = '0;
  logic                      rsp_valid;
  logic                      rsp_ready      = 1'b0;
  logic                      found;
  logic [DIST_OUT_BITS-1:0]  total_distance;
  logic [VERTEX_BITS-1:0]    path_vertex;
  logic                      last;

  // Our own copy of the block's state: the edge weights and the vertex count.
  logic [WEIGHT_IN_BITS-1:0] weight_copy [VERTEX_SLOTS][VERTEX_SLOTS];
  logic [VC_BITS-1:0]        count_setting = VC_RESET;

  request_t   request_backlog [$];
  path_step_t route_expect [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;   // suppress all idling on both sides

  always #5 clk = ~clk;

  shortest_path_dense_graph uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .mode           (mode),
    .edge_from      (edge_from),
    .edge_to        (edge_to),
    .edge_weight    (edge_weight),
    .source         (source),
    .destination    (destination),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .found          (found),
    .total_distance (total_distance),
    .path_vertex    (path_vertex),
    .last           (last)
  );

  initial begin
    for (int r = 0; r < VERTEX_SLOTS; r++)
      for (int c = 0; c < VERTEX_SLOTS; c++)
        weight_copy[r][c] = '0;
  end

  // Vertices in use: zero acts as one, anything above the capacity is cut down.
  function automatic int unsigned active_vertices();
    int unsigned n;
    n = (count_setting == 0) ? 1 : count_setting;
    if (n > VERTEX_SLOTS) n = VERTEX_SLOTS;
    if (n > MAX_RESULTS) n = MAX_RESULTS;
    return n;
  endfunction

  function automatic path_step_t make_step(input bit hit, input int unsigned dist_val,
                                           input int unsigned vertex, input bit tail);
    path_step_t s;
    s.found          = hit;
    s.total_distance = (dist_val > DIST_CAP) ? DIST_CAP : dist_val[DIST_OUT_BITS-1:0];
    s.path_vertex    = vertex[VERTEX_BITS-1:0];
    s.last           = tail;
    return s;
  endfunction

  // Run Dijkstra over our weight copy and queue the route steps it reports.
  task automatic predict_route(input logic [VERTEX_BITS-1:0] src,
                               input logic [VERTEX_BITS-1:0] dst);
    int unsigned n, u, v, nd, depth;
    int unsigned best [VERTEX_SLOTS];
    bit          reached [VERTEX_SLOTS];
    bit          settled [VERTEX_SLOTS];
    int          prev [VERTEX_SLOTS];
    int unsigned trail [MAX_RESULTS];
    bit          any;
    n = active_vertices();
    // An end point outside the vertices in use gives the not-found step.
    if (src >= n || dst >= n) begin
      route_expect.push_back(make_step(1'b0, 0, 0, 1'b1));
      return;
    end
    for (v = 0; v < n; v++) begin
      best[v]    = 0;
      reached[v] = 1'b0;
      settled[v] = 1'b0;
      prev[v]    = -1;
    end
    reached[src] = 1'b1;
    for (int round = 0; round + 1 < n; round++) begin
      any = 1'b0;
      u   = 0;
      // Pick the nearest unsettled vertex; ties go to the highest index and an
      // unreached vertex counts as farther than any reached one.
      for (v = 0; v < n; v++) begin
        if (settled[v]) continue;
        if (!any) begin
          any = 1'b1;
          u   = v;
          continue;
        end
        if (!reached[v]) begin
          if (!reached[u]) u = v;
        end else if (!reached[u] || best[v] <= best[u]) begin
          u = v;
        end
      end
      if (!any) break;
      settled[u] = 1'b1;
      // An unreached pick relaxes nothing.
      if (!reached[u]) continue;
      for (v = 0; v < n; v++) begin
        if (settled[v] || weight_copy[u][v] == 0) continue;
        nd = best[u] + weight_copy[u][v];
        if (!reached[v] || nd < best[v]) begin
          best[v]    = nd;
          reached[v] = 1'b1;
          prev[v]    = u;
        end
      end
    end
    if (!reached[dst]) begin
      route_expect.push_back(make_step(1'b0, 0, 0, 1'b1));
      return;
    end
    // Walk back from the destination, then report from the source onward.
    depth = 0;
    v = dst;
    trail[depth] = v;
    depth++;
    while (prev[v] >= 0 && depth < MAX_RESULTS) begin
      v = prev[v];
      trail[depth] = v;
      depth++;
    end
    for (int k = 0; k < depth; k++)
      route_expect.push_back(make_step(1'b1, best[dst], trail[depth - 1 - k],
                                       k + 1 == depth));
  endtask

  task automatic push_load(input int unsigned from_v, input int unsigned to_v,
                           input logic [WEIGHT_IN_BITS-1:0] w);
    request_t r;
    r.mode        = MODE_LOAD;
    r.edge_from   = from_v[VERTEX_BITS-1:0];
    r.edge_to     = to_v[VERTEX_BITS-1:0];
    r.edge_weight = w;
    // Fill the query fields with noise; a load must ignore them.
    r.source      = VERTEX_BITS'($urandom);
    r.destination = VERTEX_BITS'($urandom);
    r.drain_first = 1'b0;
    request_backlog.push_back(r);
  endtask

  task automatic push_query(input int unsigned src, input int unsigned dst,
                            input bit drain);
    request_t r;
    r.mode        = MODE_QUERY;
    r.edge_from   = VERTEX_BITS'($urandom);
    r.edge_to     = VERTEX_BITS'($urandom);
    r.edge_weight = WEIGHT_IN_BITS'($urandom);
    r.source      = src[VERTEX_BITS-1:0];
    r.destination = dst[VERTEX_BITS-1:0];
    r.drain_first = drain;
    request_backlog.push_back(r);
  endtask

  // Mostly a vertex in use, sometimes any vertex at all.
  function automatic int unsigned pick_vertex(input int unsigned n);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, VERTEX_SLOTS - 1);
  endfunction

  // Mix of loads and queries over the vertices in use. Small weights dominate
  // so that ties and alternative routes show up often; zeros cut edges away.
  task automatic random_phase(input int unsigned items, input bit drain_all);
    int unsigned n, roll;
    logic [WEIGHT_IN_BITS-1:0] w;
    n = active_vertices();
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 60) begin
        roll = $urandom_range(0, 99);
        if (roll < 10)      w = '0;
        else if (roll < 20) w = '1;
        else if (roll < 35) w = WEIGHT_IN_BITS'($urandom);
        else                w = WEIGHT_IN_BITS'($urandom_range(1, 9));
        push_load(pick_vertex(n), pick_vertex(n), w);
      end else begin
        push_query(pick_vertex(n), pick_vertex(n),
                   drain_all || ($urandom_range(0, 99) < 5));
      end
    end
  endtask

  // Wait until every request is in and every route step is out, then give any
  // trailing load time to land and wait for the sequencer to idle.
  task automatic settle();
    while (request_backlog.size() != 0 || req_valid || route_expect.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
    while (!req_ready) @(negedge clk);
  endtask

  task automatic write_count(input logic [VC_BITS-1:0] value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    count_setting  =  value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Driver: present the next backlog request once the slot frees, with random
  // idle cycles; predict each request at the edge it is accepted.
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    bit       present;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        if (mode == MODE_LOAD) weight_copy[edge_from][edge_to] = edge_weight;
        else predict_route(source, destination);
      end
      // Hold a request that has not been taken; otherwise pick what comes next.
      if (!req_valid || req_ready) begin
        present = 1'b0;
        if (request_backlog.size() != 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          // A draining request waits until no route step is outstanding; the
          // check on rsp_valid keeps it free of the monitor's pop this edge.
          if (!request_backlog[0].drain_first ||
              (route_expect.size() == 0 && !rsp_valid))
            present = 1'b1;
        end
        if (present) begin
          nxt = request_backlog.pop_front();
          mode        <= nxt.mode;
          edge_from   <= nxt.edge_from;
          edge_to     <= nxt.edge_to;
          edge_weight <= nxt.edge_weight;
          source      <= nxt.source;
          destination <= nxt.destination;
        end
        req_valid <= present;
      end
    end
  end

  // Monitor: check each accepted route step against the oldest prediction,
  // and stall the result channel at random.
  always @(posedge clk) begin : check_results
    path_step_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (route_expect.size() == 0) begin
          $error("route step with no prediction waiting: found=%0d vertex=%0d",
                 found, path_vertex);
          error_count++;
        end else begin
          want = route_expect.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            error_count++;
          end
          if (total_distance !== want.total_distance) begin
            $error("total_distance: expected %0d, got %0d",
                   want.total_distance, total_distance);
            error_count++;
          end
          if (path_vertex !== want.path_vertex) begin
            $error("path_vertex: expected %0d, got %0d", want.path_vertex, path_vertex);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            error_count++;
          end
        end
      end
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Guard against a hang; the weight sweep after reset is well inside this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VC_BITS-1:0] phase_counts [10];
    phase_counts = '{5'd16, 5'd2, 5'd5, 5'd17, 5'd31, 5'd1, 5'd8, 5'd0, 5'd16, 5'd16};
    phase_counts[7] = VC_BITS'($urandom_range(0, 31));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset vertex count, starting from an empty graph.
    @(negedge clk);
    push_query(0, 5, 1'b0);                 // nothing loaded: not found
    push_query(7, 7, 1'b0);                 // source equals destination
    for (int i = 0; i < 15; i++)            // longest chain at the largest weight
      push_load(i, i + 1, '1);
    push_query(0, 15, 1'b1);                // full-length route, drained first
    push_query(15, 0, 1'b0);                // edges point one way only
    push_load(1, 3, '1);                    // shortcut ties vertex 3 with vertex 2
    push_query(0, 4, 1'b0);
    push_load(1, 3, '0);                    // weight zero removes the shortcut
    push_query(0, 3, 1'b0);
    settle();

    // Zero acts as one vertex; any other end point is out of range.
    write_count(5'd0);
    @(negedge clk);
    push_query(0, 0, 1'b0);
    push_query(0, 1, 1'b0);
    settle();

    // Above the capacity: cut down to all sixteen vertices.
    write_count(5'd31);
    @(negedge clk);
    push_query(3, 15, 1'b0);
    settle();

    // Small count: route inside the range, end point beyond it.
    write_count(5'd4);
    @(negedge clk);
    push_query(0, 3, 1'b0);
    push_query(0, 5, 1'b0);
    push_query(6, 1, 1'b0);
    settle();

    // Random part, one vertex count per phase. The second to last phase runs
    // with no idling at all; the last holds every query until the block drains.
    for (int p = 0; p < 10; p++) begin
      write_count(phase_counts[p]);
      steady = (p == 8);
      @(negedge clk);
      random_phase(19, p == 9);
      settle();
    end
    steady = 1'b0;

    // Leave room for any stray result after the last expected one.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/spdg_pkg.sv
rtl/spdg_alu.sv
rtl/shortest_path_dense_graph.sv
dv/shortest_path_dense_graph_test.sv
